>>> rtl/control_frame_builder_xor_bcc_defines.svh
// ----------------------------------------------------------------------------
// Control frame builder assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CONTROL_FRAME_BUILDER_XOR_BCC_DEFINES_SVH
`define CONTROL_FRAME_BUILDER_XOR_BCC_DEFINES_SVH

`ifndef SYNTHESIS
`define CFB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define CFB_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define CFB_ASSERT(label, clk, rst, prop)
`define CFB_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> rtl/cfb_pkg.sv
// ----------------------------------------------------------------------------
// Control frame builder package
// Request kinds, frame characters, queued request layout and helpers.
// ----------------------------------------------------------------------------
package cfb_pkg;

   typedef enum logic [1:0] {
      KIND_CMD  = 2'd0,
      KIND_GET  = 2'd1,
      KIND_SET  = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef enum logic {
      BK_IDLE,
      BK_SEND
   } bk_state_type;

   localparam logic [7:0] CSR_RESERVE = 8'd0;
   localparam logic [7:0] CSR_SOURCE  = 8'd1;
   localparam logic [7:0] CSR_RESET   = 8'h30;

   localparam logic [7:0] CHR_SOH  = 8'h01;
   localparam logic [7:0] CHR_STX  = 8'h02;
   localparam logic [7:0] CHR_ETX  = 8'h03;
   localparam logic [7:0] CHR_CR   = 8'h0D;
   localparam logic [7:0] CHR_ZERO = 8'h30;
   localparam logic [7:0] CHR_A    = 8'h41;
   localparam logic [7:0] CHR_C    = 8'h43;
   localparam logic [7:0] CHR_E    = 8'h45;

   localparam logic [4:0] LAST_CMD = 5'd12;
   localparam logic [4:0] LAST_GET = 5'd14;
   localparam logic [4:0] LAST_SET = 5'd18;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  dest_id;
      logic [7:0]  body_length;
      logic [7:0]  cmd_code;
      logic [7:0]  page_code;
      logic [7:0]  op_code;
      logic [31:0] value_chars;
   } request_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'd0, nib};
      if (nib < 4'd10) begin
         hex_char = 8'(CHR_ZERO + wide);
      end else begin
         hex_char = 8'(CHR_A - 8'd10 + wide);
      end
   endfunction

   function automatic logic [4:0] frame_last(input kind_type kind);
      unique case (kind)
         KIND_GET: frame_last = LAST_GET;
         KIND_SET: frame_last = LAST_SET;
         default:  frame_last = LAST_CMD;
      endcase
   endfunction

endpackage

>>> rtl/control_frame_builder_xor_bcc.sv
// ----------------------------------------------------------------------------
// Control frame builder with XOR block check
// A request reaches the result ports through queue, held and output registers.
// The back-end byte sequencer sends 13, 15 or 19 words (command, get, set) per
// frame, one per cycle while the output is free; a 2-entry queue decouples.
// Reset clears queue, sequencer and output valid flag; config returns to 0x30.
// ----------------------------------------------------------------------------
module control_frame_builder_xor_bcc
   import cfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_dest_id,
   input  logic [7:0]  req_body_length,
   input  logic [7:0]  req_cmd_code,
   input  logic [7:0]  req_page_code,
   input  logic [7:0]  req_op_code,
   input  logic [31:0] req_value_chars,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_byte
);

   logic        q_valid;
   logic        q_take;
   request_type q_req;

   cfb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_type        (req_type),
      .req_dest_id     (req_dest_id),
      .req_body_length (req_body_length),
      .req_cmd_code    (req_cmd_code),
      .req_page_code   (req_page_code),
      .req_op_code     (req_op_code),
      .req_value_chars (req_value_chars),
      .q_valid         (q_valid),
      .q_req           (q_req),
      .q_take          (q_take)
   );

   cfb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .q_valid       (q_valid),
      .q_req         (q_req),
      .q_take        (q_take),
      .empty         (empty),
      .pop           (pop),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

>>> rtl/cfb_front.sv
// ----------------------------------------------------------------------------
// Control frame builder front end
// Accepts requests, drops the unused kind and queues the rest for the back end.
// ----------------------------------------------------------------------------
module cfb_front
   import cfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_dest_id,
   input  logic [7:0]  req_body_length,
   input  logic [7:0]  req_cmd_code,
   input  logic [7:0]  req_page_code,
   input  logic [7:0]  req_op_code,
   input  logic [31:0] req_value_chars,
   output logic        q_valid,
   output request_type q_req,
   input  logic        q_take
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   request_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   request_type        incoming;
   logic               wr_en;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_req   = mem_ff[rd_ptr_ff];

   always_comb begin
      incoming.kind        = kind_type'(req_type);
      incoming.dest_id     = req_dest_id;
      incoming.body_length = req_body_length;
      incoming.cmd_code    = req_cmd_code;
      incoming.page_code   = req_page_code;
      incoming.op_code     = req_op_code;
      incoming.value_chars = req_value_chars;
   end

   // drop the unused kind at the door
   assign wr_en = push && !full && (incoming.kind != KIND_NONE);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (q_take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (wr_en && !q_take) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (!wr_en && q_take) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

>>> rtl/cfb_back.sv
// ----------------------------------------------------------------------------
// Control frame builder back end
// Sequences frame bytes with a running XOR check into an output register, one
// per cycle while that register is free; holds the configuration registers.
// ----------------------------------------------------------------------------
`include "control_frame_builder_xor_bcc_defines.svh"

module cfb_back
   import cfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data,
   input  logic        q_valid,
   input  request_type q_req,
   output logic        q_take,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_byte
);

   bk_state_type state_ff, state_in;
   logic [4:0]   idx_ff, idx_in;
   logic [7:0]   bcc_ff, bcc_in;
   request_type  held_ff, held_in;
   logic [7:0]   reserve_ff, source_ff;
   logic         out_valid_ff, out_valid_in;
   logic [7:0]   out_byte_ff, out_byte_in;
   logic         out_last_ff, out_last_in;
   logic [7:0]   cur_byte;
   logic [4:0]   last_idx;
   logic         is_last;
   logic         out_free;
   logic         emit;
   logic [7:0]   letter;

   assign csr_ready     = 1'b1;
   assign empty         = !out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_last_byte = out_last_ff;
   assign out_free      = !out_valid_ff || pop;
   assign last_idx      = frame_last(held_ff.kind);
   assign is_last       = (idx_ff == last_idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         reserve_ff <= CSR_RESET;
         source_ff  <= CSR_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_RESERVE) begin
            reserve_ff <= csr_data;
         end else if (csr_index == CSR_SOURCE) begin
            source_ff <= csr_data;
         end
      end
   end

   always_comb begin
      unique case (held_ff.kind)
         KIND_GET: letter = CHR_C;
         KIND_SET: letter = CHR_E;
         default:  letter = CHR_A;
      endcase
   end

   always_comb begin
      priority if (is_last) begin
         cur_byte = CHR_CR;
      end else if (idx_ff == 5'(last_idx - 5'd1)) begin
         cur_byte = bcc_ff;
      end else if (idx_ff == 5'(last_idx - 5'd2)) begin
         cur_byte = CHR_ETX;
      end else begin
         unique case (idx_ff)
            5'd0:    cur_byte = CHR_SOH;
            5'd1:    cur_byte = reserve_ff;
            5'd2:    cur_byte = held_ff.dest_id;
            5'd3:    cur_byte = source_ff;
            5'd4:    cur_byte = letter;
            5'd5:    cur_byte = hex_char(held_ff.body_length[7:4]);
            5'd6:    cur_byte = hex_char(held_ff.body_length[3:0]);
            5'd7:    cur_byte = CHR_STX;
            5'd8:    cur_byte = (held_ff.kind == KIND_CMD) ?
                                hex_char(held_ff.cmd_code[7:4]) :
                                hex_char(held_ff.page_code[7:4]);
            5'd9:    cur_byte = (held_ff.kind == KIND_CMD) ?
                                hex_char(held_ff.cmd_code[3:0]) :
                                hex_char(held_ff.page_code[3:0]);
            5'd10:   cur_byte = hex_char(held_ff.op_code[7:4]);
            5'd11:   cur_byte = hex_char(held_ff.op_code[3:0]);
            5'd12:   cur_byte = held_ff.value_chars[31:24];
            5'd13:   cur_byte = held_ff.value_chars[23:16];
            5'd14:   cur_byte = held_ff.value_chars[15:8];
            5'd15:   cur_byte = held_ff.value_chars[7:0];
            default: cur_byte = CHR_CR;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      bcc_in       = bcc_ff;
      held_in      = held_ff;
      q_take       = 1'b0;
      emit         = 1'b0;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !pop;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               held_in  = q_req;
               q_take   = 1'b1;
               idx_in   = '0;
               state_in = BK_SEND;
            end
         end
         BK_SEND: begin
            if (out_free) begin
               emit = 1'b1;
               if (idx_ff == '0) begin
                  bcc_in = '0;
               end else if (idx_ff <= 5'(last_idx - 5'd2)) begin
                  bcc_in = bcc_ff ^ cur_byte;
               end
               if (is_last) begin
                  idx_in = '0;
                  if (q_valid) begin
                     held_in = q_req;
                     q_take  = 1'b1;
                  end else begin
                     state_in = BK_IDLE;
                  end
               end else begin
                  idx_in = 5'(idx_ff + 5'd1);
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = cur_byte;
         out_last_in  = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         idx_ff       <= '0;
         bcc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         bcc_ff       <= bcc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff     <= held_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   `CFB_ASSERT(a_last_is_cr, clock, reset, out_valid_ff && out_last_ff |-> out_byte_ff == CHR_CR)
   `CFB_ASSERT(a_idx_bound, clock, reset, state_ff == BK_SEND |-> idx_ff <= last_idx)
   `CFB_ASSERT(a_hold_word, clock, reset, out_valid_ff && !pop |=> out_valid_ff && $stable(out_byte_ff))
   `CFB_ASSERT_ALWAYS(a_take_valid, clock, !reset && q_take |-> q_valid)

endmodule

>>> tb/sv/control_frame_builder_xor_bcc_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Control frame builder testbench
// Queues requests of every kind to the frame builder, rebuilds each frame
// byte by byte, with its XOR check byte, and compares every popped word in
// order. Both sides idle at random. The receiver once holds off long enough
// to back the block up. The reserve and source registers are rewritten
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module control_frame_builder_xor_bcc_tb;
   import cfb_pkg::*;

   localparam int IDLE_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_AT_WORD = 400;
   localparam int HOLD_CYCLES = 150;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } frame_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;
   logic        push = 1'b0;
   logic        full;
   logic [1:0]  req_type = '0;
   logic [7:0]  req_dest_id = '0;
   logic [7:0]  req_body_length = '0;
   logic [7:0]  req_cmd_code = '0;
   logic [7:0]  req_page_code = '0;
   logic [7:0]  req_op_code = '0;
   logic [31:0] req_value_chars = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_byte;

   request_type    request_queue[$];
   frame_word_type frame_words[$];

   logic [7:0] reserve_cfg = CSR_RESET;
   logic [7:0] source_cfg = CSR_RESET;

   int error_count = 0;
   int words_checked = 0;
   int config_writes = 0;
   int frames_by_kind[4] = '{0, 0, 0, 0};
   int idle_cycles = 0;

   control_frame_builder_xor_bcc DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .push            (push),
      .full            (full),
      .req_type        (req_type),
      .req_dest_id     (req_dest_id),
      .req_body_length (req_body_length),
      .req_cmd_code    (req_cmd_code),
      .req_page_code   (req_page_code),
      .req_op_code     (req_op_code),
      .req_value_chars (req_value_chars),
      .empty           (empty),
      .pop             (pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] ascii_nibble(input logic [3:0] nib);
      if (nib < 4'd10) begin
         return CHR_ZERO + {4'd0, nib};
      end
      return CHR_A + {4'd0, nib} - 8'd10;
   endfunction

   // Build the frame for one accepted request and queue its words.
   function automatic void predict_frame(input request_type r);
      logic [7:0] bytes[$];
      logic [7:0] bcc;
      frame_word_type w;
      if (r.kind == KIND_NONE) begin
         return;
      end
      bytes.push_back(CHR_SOH);
      bytes.push_back(reserve_cfg);
      bytes.push_back(r.dest_id);
      bytes.push_back(source_cfg);
      case (r.kind)
         KIND_CMD: bytes.push_back(CHR_A);
         KIND_GET: bytes.push_back(CHR_C);
         default:  bytes.push_back(CHR_E);
      endcase
      bytes.push_back(ascii_nibble(r.body_length[7:4]));
      bytes.push_back(ascii_nibble(r.body_length[3:0]));
      bytes.push_back(CHR_STX);
      if (r.kind == KIND_CMD) begin
         bytes.push_back(ascii_nibble(r.cmd_code[7:4]));
         bytes.push_back(ascii_nibble(r.cmd_code[3:0]));
      end else begin
         bytes.push_back(ascii_nibble(r.page_code[7:4]));
         bytes.push_back(ascii_nibble(r.page_code[3:0]));
         bytes.push_back(ascii_nibble(r.op_code[7:4]));
         bytes.push_back(ascii_nibble(r.op_code[3:0]));
         if (r.kind == KIND_SET) begin
            bytes.push_back(r.value_chars[31:24]);
            bytes.push_back(r.value_chars[23:16]);
            bytes.push_back(r.value_chars[15:8]);
            bytes.push_back(r.value_chars[7:0]);
         end
      end
      bytes.push_back(CHR_ETX);
      bcc = '0;
      for (int i = 1; i < bytes.size(); i++) begin
         bcc ^= bytes[i];
      end
      bytes.push_back(bcc);
      bytes.push_back(CHR_CR);
      for (int i = 0; i < bytes.size(); i++) begin
         w.data = bytes[i];
         w.last = (i == bytes.size() - 1);
         frame_words.push_back(w);
      end
   endfunction

   // Idle draw with occasional stretches of back-to-back words.
   function automatic int idle_draw(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst = $urandom_range(8, 30);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   // Driver: present queued requests, hold each until accepted.
   int push_gap = 0;
   int push_burst = 0;
   always @(posedge clock) begin
      logic push_now;
      request_type r;
      if (reset) begin
         push <= 1'b0;
      end else begin
         push_now = push;
         if (push && !full) begin
            r.kind        = kind_type'(req_type);
            r.dest_id     = req_dest_id;
            r.body_length = req_body_length;
            r.cmd_code    = req_cmd_code;
            r.page_code   = req_page_code;
            r.op_code     = req_op_code;
            r.value_chars = req_value_chars;
            predict_frame(r);
            frames_by_kind[req_type]++;
            push_now = 1'b0;
            push_gap = idle_draw(push_burst);
         end
         if (!push_now) begin
            if (push_gap > 0) begin
               push_gap--;
            end else if (request_queue.size() > 0) begin
               r = request_queue.pop_front();
               req_type        <= r.kind;
               req_dest_id     <= r.dest_id;
               req_body_length <= r.body_length;
               req_cmd_code    <= r.cmd_code;
               req_page_code   <= r.page_code;
               req_op_code     <= r.op_code;
               req_value_chars <= r.value_chars;
               push_now = 1'b1;
            end
         end
         push <= push_now;
      end
   end

   // Monitor: pop words, compare with the oldest expected word.
   int pop_gap = 0;
   int pop_burst = 0;
   int hold_left = 0;
   always @(posedge clock) begin
      logic pop_now;
      frame_word_type w;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         pop_now = pop;
         if (pop && !empty) begin
            if (frame_words.size() == 0) begin
               $error("unexpected word: out_byte %h last_byte %b", rsp_out_byte,
                      rsp_last_byte);
               error_count++;
            end else begin
               w = frame_words.pop_front();
               if (rsp_out_byte !== w.data) begin
                  $error("out_byte mismatch: expected %h, actual %h", w.data, rsp_out_byte);
                  error_count++;
               end
               if (rsp_last_byte !== w.last) begin
                  $error("last_byte mismatch: expected %b, actual %b", w.last,
                         rsp_last_byte);
                  error_count++;
               end
            end
            words_checked++;
            if (words_checked == HOLD_AT_WORD) begin
               hold_left = HOLD_CYCLES;
            end
            pop_now = 1'b0;
            pop_gap = idle_draw(pop_burst);
         end
         if (!pop_now) begin
            if (hold_left > 0) begin
               hold_left--;
            end else if (pop_gap > 0) begin
               pop_gap--;
            end else begin
               pop_now = 1'b1;
            end
         end
         pop <= pop_now;
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic add_request(input kind_type kind, input logic [7:0] dest,
                              input logic [7:0] blen, input logic [7:0] cmd,
                              input logic [7:0] page, input logic [7:0] op,
                              input logic [31:0] val);
      request_type r;
      r.kind        = kind;
      r.dest_id     = dest;
      r.body_length = blen;
      r.cmd_code    = cmd;
      r.page_code   = page;
      r.op_code     = op;
      r.value_chars = val;
      request_queue.push_back(r);
   endtask

   task automatic add_random_requests(input int count);
      kind_type kind;
      for (int i = 0; i < count; i++) begin
         kind = ($urandom_range(0, 9) == 0) ? KIND_NONE : kind_type'($urandom_range(0, 2));
         add_request(kind, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), $urandom);
      end
   endtask

   // Wait until every word is out, then let in-flight work settle.
   task automatic drain_and_settle();
      while (request_queue.size() != 0 || push || frame_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [7:0] index, input logic [7:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      forever begin
         @(posedge clock);
         if (csr_ready) begin
            break;
         end
      end
      if (index == CSR_RESERVE) begin
         reserve_cfg = data;
      end else if (index == CSR_SOURCE) begin
         source_cfg = data;
      end
      config_writes++;
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset values of the registers
      add_request(KIND_CMD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0000_0000);
      add_request(KIND_GET, 8'h30, 8'h09, 8'h00, 8'h0A, 8'hF9, 32'h0000_0000);
      add_request(KIND_SET, 8'h41, 8'h1F, 8'h00, 8'h2E, 8'hD3, 32'h3031_3233);
      add_request(KIND_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
      add_request(KIND_CMD, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 32'h0000_0000);
      drain_and_settle();

      write_csr(CSR_RESERVE, 8'h00);
      write_csr(CSR_SOURCE, 8'hFF);
      add_request(KIND_CMD, 8'h5A, 8'hA5, 8'h9A, 8'h00, 8'h00, 32'h0000_0000);
      add_request(KIND_CMD, 8'h00, 8'hAB, 8'hCD, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
      add_request(KIND_GET, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 32'h0000_0000);
      add_request(KIND_GET, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 32'hFFFF_FFFF);
      add_request(KIND_SET, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0000_0000);
      add_request(KIND_SET, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
      add_request(KIND_SET, 8'h01, 8'h13, 8'h00, 8'h45, 8'h67, 32'h0001_0D00);
      add_request(KIND_NONE, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 32'hDEAD_BEEF);
      add_request(KIND_SET, 8'h80, 8'hEF, 8'h12, 8'hBC, 8'h89, 32'h8000_0001);
      add_request(KIND_GET, 8'h7F, 8'h8C, 8'h34, 8'h56, 8'h7E, 32'h0000_0000);
      add_request(KIND_CMD, 8'h0D, 8'h67, 8'hB8, 8'h00, 8'h00, 32'h0000_0000);
      add_request(KIND_SET, 8'h02, 8'h99, 8'h00, 8'hAA, 8'h55, 32'h0203_0D01);
      drain_and_settle();

      write_csr(CSR_RESERVE, 8'($urandom));
      write_csr(CSR_SOURCE, 8'($urandom));
      add_random_requests(28);
      drain_and_settle();

      write_csr(CSR_RESERVE, 8'hFF);
      write_csr(CSR_SOURCE, 8'h00);
      add_random_requests(28);
      drain_and_settle();

      write_csr(CSR_SOURCE, 8'($urandom));
      write_csr(CSR_RESERVE, 8'($urandom));
      add_random_requests(28);
      drain_and_settle();
      repeat (20) @(posedge clock);

      $display("frames checked: %0d command, %0d get, %0d set, %0d ignored requests",
               frames_by_kind[KIND_CMD], frames_by_kind[KIND_GET],
               frames_by_kind[KIND_SET], frames_by_kind[KIND_NONE]);
      $display("words checked: %0d, register writes: %0d, errors: %0d",
               words_checked, config_writes, error_count);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
